/* rtl/core/sgas_pkg.sv */
// ----------------------------------------------------------------------------
// sgas_pkg
// Shared types and codes for the softened gravity acceleration engine.
// ----------------------------------------------------------------------------
package sgas_pkg;

    // input word opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SOFTENING = 2'd0;
    localparam logic [1:0] CFG_ACTIVE    = 2'd1;
    localparam logic [1:0] CFG_ROUND     = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ENTRY_W    = 128;
    localparam int ACC_W      = 48;
    localparam int MAG_W      = 49;   // term magnitude, up to 2^48
    localparam int QUO_W      = 52;   // divider quotient
    localparam int NORM_W     = 67;   // normalizer window

    typedef logic [ACC_W-1:0] acc_t;
    typedef logic [MAG_W-1:0] mag_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DIFF,
        ST_SQR,
        ST_PROD,
        ST_SUM,
        ST_NORM,
        ST_CUBE1,
        ST_CUBE2,
        ST_SQRT,
        ST_DIV,
        ST_MAG,
        ST_ACC,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/sgas_ram.sv */
// ----------------------------------------------------------------------------
// sgas_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sgas_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/softened_gravity_accel_sum.sv */
// ----------------------------------------------------------------------------
// softened_gravity_accel_sum
// Plummer-softened direct-sum gravity engine over a body store in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one word per item. A load word
//   (op = load) writes x, y, z and mass into body RAM entry 'slot' in the
//   accept cycle and gives no result. A query word (op = query) gives a probe
//   position; the engine walks entries 0 .. min(active_bodies, MAX_BODIES)-1
//   and returns one output word (acc_x/y/z, saturated) on out_valid/out_stall.
//   Config writes (cfg_write, cfg_index, cfg_data) are registered; the user
//   must make them only while the engine is idle, which the block does not enforce.
// Query processing:
//   A load does not stall the input. A query holds the input stalled while it
//   runs; each body passes a normalizer of j steps (0..33), a 32-step square
//   root and the bit-serial divider (one quotient bit per cycle, three axes in
//   parallel), which runs longer for larger fb = 41 - 3k (minus 16 with
//   round_terms) for shift k.
// Reset:
//   rst_n clears control and config registers; the body RAM is not cleared
//   and entries must be loaded before a query reads them.
// Stall:
//   A finished result sits in the output register; the next load is taken
//   while it waits. A later query finishing before the word is taken waits
//   in its final state until the output register frees up.
// ----------------------------------------------------------------------------
module softened_gravity_accel_sum #(
    parameter int MAX_BODIES = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_write,
    input  logic [sgas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sgas_pkg::CFG_DATA_W-1:0] cfg_data,
    // input words
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         op,
    input  logic [7:0]                   slot,
    input  logic signed [31:0]           pos_x,
    input  logic signed [31:0]           pos_y,
    input  logic signed [31:0]           pos_z,
    input  logic [31:0]                  mass,
    // output words
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [47:0]           acc_x,
    output logic signed [47:0]           acc_y,
    output logic signed [47:0]           acc_z,
    output logic                         saturated
);

    import sgas_pkg::*;

    localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CW = $clog2(MAX_BODIES + 1);
    localparam logic [MAG_W-1:0] TERM_CAP = MAG_W'(1) << 48;
    localparam logic [QUO_W-1:0] QUO_CAP  = QUO_W'(1) << 51;

    // ---------------- config registers ----------------
    logic [31:0] soft_reg;
    logic [8:0]  active_reg;
    logic        round_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            soft_reg   <= 32'd65536;
            active_reg <= 9'd0;
            round_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SOFTENING: soft_reg   <= cfg_data;
                CFG_ACTIVE:    active_reg <= cfg_data[8:0];
                CFG_ROUND:     round_reg  <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // ---------------- control ----------------
    state_t state_reg, state_next;
    logic   in_acc;
    logic   out_free;
    logic   ram_re;
    logic   ram_we;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [CW-1:0] idx_reg, cnt_reg, cnt_next;
    logic [4:0]    sq_j_reg;
    logic [7:0]    div_cnt_reg;
    logic [7:0]    div_len;
    logic          s_zero;
    logic          last_body;

    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid || !out_stall;
    assign last_body = (idx_reg + CW'(1)) == cnt_reg;
    assign cnt_next  = (32'(active_reg) > MAX_BODIES) ? CW'(MAX_BODIES) : CW'(active_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && op == OP_QUERY)
                begin
                    state_next = (cnt_next == '0) ? ST_DONE : ST_READ;
                end
            end
            ST_READ:  state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_SQR;
            ST_SQR:   state_next = ST_PROD;
            ST_PROD:  state_next = ST_SUM;
            ST_SUM:   state_next = s_zero ? ST_ACC : ST_NORM;
            ST_NORM:  state_next = ST_CUBE1;
            ST_CUBE1: state_next = ST_CUBE2;
            ST_CUBE2: state_next = ST_SQRT;
            ST_SQRT:  state_next = (sq_j_reg == 5'd0) ? ST_DIV : ST_SQRT;
            ST_DIV:   state_next = (div_cnt_reg == div_len - 8'd1) ? ST_MAG : ST_DIV;
            ST_MAG:   state_next = ST_ACC;
            ST_ACC:   state_next = last_body ? ST_DONE : ST_READ;
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic norm_done;

    // ST_NORM loops on itself until the window is normalized
    state_t state_eff;
    assign state_eff = (state_reg == ST_NORM && !norm_done) ? ST_NORM : state_next;

    // outputs of the sequencer
    always_comb
    begin
        in_stall = 1'b1;
        ram_re   = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_READ: ram_re   = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_eff;
        end
    end

    // ---------------- body RAM ----------------
    assign ram_we = in_acc && op == OP_LOAD && (int'(slot) < MAX_BODIES);

    sgas_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_BODIES),
        .AW   (AW)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(slot)),
        .wdata({pos_x, pos_y, pos_z, mass}),
        .re   (ram_re),
        .raddr(idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    // ---------------- datapath ----------------
    logic signed [31:0] probe_reg [3];
    logic [32:0]        u_reg     [3];   // |body - probe|
    logic               neg_reg   [3];
    logic [31:0]        m_reg;
    logic [65:0]        sq_reg    [3];
    logic [63:0]        p_reg     [3];   // |d| * mass
    logic [NORM_W-1:0]  x_reg;
    logic signed [5:0]  k_reg;
    logic signed [7:0]  fb_reg;
    logic [41:0]        s2_reg;
    logic [20:0]        s_reg;
    logic [63:0]        v_reg, res_reg;
    logic [31:0]        c_reg;
    logic [31:0]        r_reg     [3];
    logic [QUO_W-1:0]   q_reg     [3];
    logic               cap_reg   [3];
    mag_t               mag_reg   [3];
    acc_t               acc_reg   [3];
    logic               sat_reg;

    logic [65:0]        s_sum;
    logic signed [32:0] dd        [3];
    logic [31:0]        bpos      [3];
    logic [63:0]        sq_bit;
    logic [63:0]        sq_try;
    logic               dbit;
    logic [32:0]        r_sh      [3];
    logic signed [7:0]  fb_calc;
    logic [ACC_W:0]     acc_res   [3];   // {clip, value}

    assign bpos[0] = ram_rdata[127:96];
    assign bpos[1] = ram_rdata[95:64];
    assign bpos[2] = ram_rdata[63:32];

    assign s_sum  = sq_reg[0] + sq_reg[1] + sq_reg[2] + {18'd0, soft_reg, 16'd0};
    assign s_zero = (s_sum == '0);
    assign norm_done = (x_reg[NORM_W-1:NORM_W-2] != 2'b00);
    assign fb_calc = 8'(41 - 3 * int'(k_reg) - (round_reg ? 16 : 0));
    assign div_len = 8'd64 + (fb_reg[7] ? 8'd0 : fb_reg);
    assign sq_bit  = 64'd1 << {sq_j_reg, 1'b0};
    assign sq_try  = res_reg + sq_bit;
    assign dbit    = div_cnt_reg[7:6] == 2'b00;   // dividend phase

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            dd[a]   = $signed({bpos[a][31], bpos[a]}) - $signed({probe_reg[a][31], probe_reg[a]});
            r_sh[a] = {r_reg[a], dbit ? p_reg[a][~div_cnt_reg[5:0]] : 1'b0};
        end
    end

    // term magnitude from the raw quotient
    function automatic mag_t term_mag(input logic [QUO_W-1:0] q, input logic cap,
                                      input logic signed [7:0] fb, input logic rt);
        logic [QUO_W-1:0] qs;
        logic [QUO_W:0]   qr;
        logic [QUO_W-1:0] m;
        mag_t             res;
        qs  = fb[7] ? (q >> 8'(-fb)) : q;
        qr  = {1'b0, qs} + (QUO_W+1)'(1);
        m   = qr[QUO_W:1];
        if (cap)
        begin
            res = TERM_CAP;
        end
        else if (rt)
        begin
            res = (m >= (QUO_W'(1) << 32)) ? TERM_CAP : {m[32:0], 16'd0};
        end
        else
        begin
            res = (m > QUO_W'(TERM_CAP)) ? TERM_CAP : m[MAG_W-1:0];
        end
        return res;
    endfunction

    // saturating accumulate: returns {clip, value}
    function automatic logic [ACC_W:0] acc_add(input acc_t acc, input logic neg,
                                                input mag_t mag);
        logic signed [ACC_W+1:0] sum;
        logic signed [ACC_W+1:0] t;
        logic [ACC_W:0]          res;
        t   = $signed({1'b0, mag});
        sum = $signed({{2{acc[ACC_W-1]}}, acc}) + (neg ? -t : t);
        if (sum > $signed((ACC_W+2)'(48'h7FFF_FFFF_FFFF)))
        begin
            res = {1'b1, 48'h7FFF_FFFF_FFFF};
        end
        else if (sum < -$signed((ACC_W+2)'(48'h8000_0000_0000)))
        begin
            res = {1'b1, 48'h8000_0000_0000};
        end
        else
        begin
            res = {1'b0, sum[ACC_W-1:0]};
        end
        return res;
    endfunction

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            acc_res[a] = acc_add(acc_reg[a], neg_reg[a], mag_reg[a]);
        end
    end

    // control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            cnt_reg     <= '0;
            sq_j_reg    <= '0;
            div_cnt_reg <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_IDLE && in_acc)
            begin
                idx_reg <= '0;
                cnt_reg <= cnt_next;
            end
            if (state_reg == ST_ACC)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
            if (state_reg == ST_CUBE2)
            begin
                sq_j_reg <= 5'd31;
            end
            else if (state_reg == ST_SQRT)
            begin
                sq_j_reg <= sq_j_reg - 5'd1;
            end
            if (state_reg == ST_SQRT)
            begin
                div_cnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 8'd1;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                probe_reg[0] <= pos_x;
                probe_reg[1] <= pos_y;
                probe_reg[2] <= pos_z;
                for (int a = 0; a < 3; a++)
                begin
                    acc_reg[a] <= '0;
                end
                sat_reg <= 1'b0;
            end
            ST_DIFF:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    neg_reg[a] <= dd[a][32];
                    u_reg[a]   <= dd[a][32] ? 33'(-dd[a]) : 33'(dd[a]);
                end
                m_reg <= ram_rdata[31:0];
            end
            ST_SQR:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    sq_reg[a] <= u_reg[a] * u_reg[a];
                end
            end
            ST_PROD:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    p_reg[a] <= 64'(u_reg[a] * {1'b0, m_reg});
                end
            end
            ST_SUM:
            begin
                x_reg    <= {1'b0, s_sum};
                k_reg    <= 6'sd23;
                if (s_zero)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        mag_reg[a] <= '0;
                    end
                end
            end
            ST_NORM:
            begin
                if (!norm_done)
                begin
                    x_reg <= x_reg << 2;
                    k_reg <= k_reg - 6'sd1;
                end
                fb_reg <= fb_calc;
            end
            ST_CUBE1:
            begin
                s_reg  <= x_reg[66:46];
                s2_reg <= x_reg[66:46] * x_reg[66:46];
            end
            ST_CUBE2:
            begin
                v_reg   <= 64'(s2_reg * s_reg);
                res_reg <= '0;
            end
            ST_SQRT:
            begin
                if (v_reg >= sq_try)
                begin
                    v_reg   <= v_reg - sq_try;
                    res_reg <= (res_reg >> 1) + sq_bit;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                for (int a = 0; a < 3; a++)
                begin
                    r_reg[a]   <= '0;
                    q_reg[a]   <= '0;
                    cap_reg[a] <= 1'b0;
                end
                if (sq_j_reg == 5'd0)
                begin
                    c_reg <= (v_reg >= sq_try) ? 32'((res_reg >> 1) + sq_bit)
                                               : 32'(res_reg >> 1);
                end
            end
            ST_DIV:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if (!dbit && q_reg[a] >= QUO_CAP)
                    begin
                        cap_reg[a] <= 1'b1;
                    end
                    else if (!cap_reg[a])
                    begin
                        if (r_sh[a] >= {1'b0, c_reg})
                        begin
                            r_reg[a] <= 32'(r_sh[a] - {1'b0, c_reg});
                            q_reg[a] <= {q_reg[a][QUO_W-2:0], 1'b1};
                        end
                        else
                        begin
                            r_reg[a] <= r_sh[a][31:0];
                            q_reg[a] <= {q_reg[a][QUO_W-2:0], 1'b0};
                        end
                    end
                end
            end
            ST_MAG:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    mag_reg[a] <= term_mag(q_reg[a], cap_reg[a], fb_reg, round_reg);
                end
            end
            ST_ACC:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    acc_reg[a] <= acc_res[a][ACC_W-1:0];
                end
                if (acc_res[0][ACC_W] || acc_res[1][ACC_W] || acc_res[2][ACC_W])
                begin
                    sat_reg <= 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    acc_x     <= acc_reg[0];
                    acc_y     <= acc_reg[1];
                    acc_z     <= acc_reg[2];
                    saturated <= sat_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

/* rtl/core/sgas_checker.sv */
// ----------------------------------------------------------------------------
// sgas_checker
// Port-level checks for the gravity engine, bound to the top level.
// ----------------------------------------------------------------------------
module sgas_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               op,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [47:0] acc_x,
    input logic               saturated
);

    import sgas_pkg::*;

    // a load never produces an output word
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_LOAD && !out_valid |=> !out_valid)
        else $error("load produced an output word");

    // a query keeps the input stalled while it runs
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_QUERY |=> in_stall)
        else $error("input not stalled after query");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(acc_x) && $stable(saturated))
        else $error("stalled output word changed");

endmodule

bind softened_gravity_accel_sum sgas_checker u_sgas_checker (.*);
